### design/bis_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler package
// Shared widths, field types and register indexes.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MaxSrcDim = 256;
  localparam int FracBits  = 16;
  localparam int DimW      = $clog2(MaxSrcDim) + 1;   // 9
  localparam int AddrW     = 2 * $clog2(MaxSrcDim);   // 16
  localparam int CoordW    = 12;
  localparam int DstW      = 13;
  localparam int ScaleW    = 20;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 20;
  // source coordinate, signed, Q.FracBits
  localparam int XsW       = 40;

  localparam logic [CfgIdxW-1:0] RegSrcCols  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSrcRows  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDstCols  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDstRows  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInvScX   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInvScY   = 3'd5;

  typedef struct packed {
    logic              func;
    logic              first;
    logic [7:0]        in_red;
    logic [7:0]        in_green;
    logic [7:0]        in_blue;
    logic [CoordW-1:0] dst_x;
    logic [CoordW-1:0] dst_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       covered;
  } out_item_t;

  // query handed from the front to the back
  typedef struct packed {
    logic                     covered;
    logic                     top;
    logic                     bot;
    logic [AddrW-1:0]         a_u;
    logic [AddrW-1:0]         a_tl;
    logic [AddrW-1:0]         a_tr;
    logic [AddrW-1:0]         a_bl;
    logic [AddrW-1:0]         a_br;
    logic signed [FracBits+2:0] d1;
    logic signed [FracBits+2:0] d2;
    logic signed [FracBits+2:0] d3;
    logic signed [FracBits+2:0] d4;
  } job_t;

endpackage

### design/bis_stream_if.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler stream interface
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface bis_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/bilinear_image_scaler.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler
// Stores an RGB source frame and answers destination queries by blending.
// ----------------------------------------------------------------------------
// A load gives no result. The back end works on one query at a time, reading
// the frame memory five times and then blending, while the front end keeps
// accepting queries until the queue fills.
// Loads are taken one per cycle once no earlier query is still in flight.
// Reset clears pointer and queue and sets the config registers to their defaults; the frame memory is not cleared.
module bilinear_image_scaler
  import bis_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  bis_stream_if.sink          in_ch,
  bis_stream_if.source        out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [DimW-1:0]   src_cols_r, src_rows_r;
  logic [DstW-1:0]   dst_cols_r, dst_rows_r;
  logic [ScaleW-1:0] inv_x_r, inv_y_r;
  logic [AddrW-1:0]  lp_r, wa;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cols_r <= DimW'(MaxSrcDim);
      src_rows_r <= DimW'(MaxSrcDim);
      dst_cols_r <= DstW'(256);
      dst_rows_r <= DstW'(256);
      inv_x_r    <= ScaleW'(1 << FracBits);
      inv_y_r    <= ScaleW'(1 << FracBits);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegSrcCols: src_cols_r <= cfg_data[DimW-1:0];
        RegSrcRows: src_rows_r <= cfg_data[DimW-1:0];
        RegDstCols: dst_cols_r <= cfg_data[DstW-1:0];
        RegDstRows: dst_rows_r <= cfg_data[DstW-1:0];
        RegInvScX:  inv_x_r    <= cfg_data[ScaleW-1:0];
        RegInvScY:  inv_y_r    <= cfg_data[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  logic adv, job_v, q_empty, q_full, pop, busy, acc, load, front_busy;
  job_t job, head;
  logic [1:0] inflight;

  // hold the front while the queue could overflow
  assign adv  = !q_full && !(inflight == 2'd2 && job_v);
  // hold a load until every earlier query has read the frame
  assign in_ch.ready = adv &&
                       !(!in_ch.data.func && (front_busy || !q_empty || busy));
  assign acc  = in_ch.valid && in_ch.ready;
  assign load = acc && !in_ch.data.func;
  assign wa   = in_ch.data.first ? '0 : lp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) lp_r <= '0;
    else if (load) lp_r <= wa + AddrW'(1);
  end

  always_comb inflight = 2'(q_empty ? 0 : (q_full ? 2 : 1));

  bis_front u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_item(in_ch.data), .adv,
    .src_cols(src_cols_r), .src_rows(src_rows_r),
    .dst_cols(dst_cols_r), .dst_rows(dst_rows_r),
    .inv_x(inv_x_r), .inv_y(inv_y_r),
    .busy(front_busy), .job_valid(job_v), .job
  );

  bis_queue u_queue (
    .clk, .rst_n, .push(job_v && adv), .push_data(job), .pop,
    .empty(q_empty), .full(q_full), .head
  );

  out_item_t res;
  bis_back u_back (
    .clk, .rst_n, .wr_en(load), .wr_addr(wa),
    .wr_data({in_ch.data.in_red, in_ch.data.in_green, in_ch.data.in_blue}),
    .job_avail(!q_empty), .job(head), .job_pop(pop), .busy,
    .res_valid(out_ch.valid), .res, .res_ready(out_ch.ready)
  );

  assign out_ch.data = res;

endmodule

### design/bis_front.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler front end
// Maps query coordinates to source neighbours and weights over two stages.
// ----------------------------------------------------------------------------
module bis_front
  import bis_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  in_item_t             in_item,
  input  logic                 adv,        // stages may move
  input  logic [DimW-1:0]      src_cols,
  input  logic [DimW-1:0]      src_rows,
  input  logic [DstW-1:0]      dst_cols,
  input  logic [DstW-1:0]      dst_rows,
  input  logic [ScaleW-1:0]    inv_x,
  input  logic [ScaleW-1:0]    inv_y,
  output logic                 busy,
  output logic                 job_valid,
  output job_t                 job
);

  localparam logic signed [XsW-1:0] FxOne  = XsW'(1) <<< FracBits;
  localparam logic signed [XsW-1:0] FxHalf = XsW'(1) <<< (FracBits - 1);

  // stage 1: products
  logic                     s1_v_r;
  logic signed [XsW-1:0]    px_r, py_r;

  logic signed [DstW+1:0] cx, cy;
  logic signed [ScaleW+1:0] sx, sy;
  always_comb begin
    cx = $signed({2'b0, in_item.dst_x, 1'b0}) - $signed({2'b0, dst_cols});
    cy = $signed({2'b0, in_item.dst_y, 1'b0}) - $signed({2'b0, dst_rows});
    sx = (inv_x == '0) ? (ScaleW+2)'(1 << FracBits) : $signed({2'b0, inv_x});
    sy = (inv_y == '0) ? (ScaleW+2)'(1 << FracBits) : $signed({2'b0, inv_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid && in_item.func;
    end
    if (adv) begin
      px_r <= XsW'(cx) * XsW'(sx);
      py_r <= XsW'(cy) * XsW'(sy);
    end
  end

  // stage 2: coordinates, neighbours, weights
  logic signed [XsW-1:0] xs, ys, ux, uy, tx, ty, pxc, nxc, pyc, nyc;
  logic in_u, in_top, in_bot;
  job_t job_nxt;

  function automatic logic signed [XsW-1:0] trunc_fb(input logic signed [XsW-1:0] v);
    logic signed [XsW-1:0] m;
    m = -v;
    trunc_fb = v[XsW-1] ? -(m >>> FracBits) : (v >>> FracBits);
  endfunction

  function automatic logic inside_x(input logic signed [XsW-1:0] v,
                                    input logic [DimW-1:0] n);
    inside_x = !v[XsW-1] && (v < $signed({{(XsW-DimW){1'b0}}, n}));
  endfunction

  function automatic logic [AddrW-1:0] addr_of(input logic signed [XsW-1:0] col,
                                               input logic signed [XsW-1:0] row,
                                               input logic [DimW-1:0] cols);
    logic [AddrW+DimW-1:0] p;
    p = row[AddrW-1:0] * cols;
    addr_of = p[AddrW-1:0] + col[AddrW-1:0];
  endfunction

  always_comb begin
    // floor of half: arithmetic shift
    xs = (px_r >>> 1) + ($signed({{(XsW-DimW){1'b0}}, src_cols}) <<< (FracBits - 1));
    ys = (py_r >>> 1) + ($signed({{(XsW-DimW){1'b0}}, src_rows}) <<< (FracBits - 1));
    ux = trunc_fb(xs + FxHalf);
    uy = trunc_fb(ys + FxHalf);
    tx = ux <<< FracBits;
    ty = uy <<< FracBits;
    if (xs < tx) begin nxc = ux; pxc = ux - 1; end
    else begin nxc = ux + 1; pxc = ux; end
    if (ys < ty) begin nyc = uy; pyc = uy - 1; end
    else begin nyc = uy + 1; pyc = uy; end
    in_u   = inside_x(ux, src_cols) && inside_x(uy, src_rows);
    in_top = inside_x(pxc, src_cols) && inside_x(nxc, src_cols)
             && inside_x(pyc, src_rows);
    in_bot = inside_x(pxc, src_cols) && inside_x(nxc, src_cols)
             && inside_x(nyc, src_rows);
    job_nxt.covered = in_u;
    job_nxt.top  = in_top;
    job_nxt.bot  = in_bot;
    job_nxt.a_u  = addr_of(ux, uy, src_cols);
    job_nxt.a_tl = addr_of(pxc, pyc, src_cols);
    job_nxt.a_tr = addr_of(nxc, pyc, src_cols);
    job_nxt.a_bl = addr_of(pxc, nyc, src_cols);
    job_nxt.a_br = addr_of(nxc, nyc, src_cols);
    job_nxt.d1 = (FracBits+3)'((nxc <<< FracBits) - xs);
    job_nxt.d2 = (FracBits+3)'(xs - (pxc <<< FracBits));
    job_nxt.d3 = (FracBits+3)'((nyc <<< FracBits) - ys);
    job_nxt.d4 = (FracBits+3)'(ys - (pyc <<< FracBits));
  end

  logic job_v_r;
  job_t job_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
    end else if (adv) begin
      job_v_r <= s1_v_r;
    end
    if (adv) begin
      job_r <= job_nxt;
    end
  end

  assign busy      = s1_v_r || job_v_r;
  assign job_valid = job_v_r;
  assign job       = job_r;

endmodule

### design/bis_queue.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler job queue
// Two-entry FIFO between front and back.
// ----------------------------------------------------------------------------
module bis_queue
  import bis_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output logic empty,
  output logic full,
  output job_t head
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= push_data;
  end

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rp_r];

endmodule

### design/bis_back.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler back end
// Owns the frame memory, fetches four neighbours and the nearest pixel per job and blends them.
// ----------------------------------------------------------------------------
module bis_back
  import bis_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [23:0] wr_data,
  input  logic       job_avail,
  input  job_t       job,
  output logic       job_pop,
  output logic       busy,
  output logic       res_valid,
  output out_item_t  res,
  input  logic       res_ready
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD0  = 6'b000010,
    S_RD1  = 6'b000100,
    S_RD2  = 6'b001000,
    S_RD3  = 6'b010000,
    S_MUL  = 6'b100000
  } bstate_t;

  logic [23:0] mem [1 << AddrW];
  logic [23:0] rd_q;
  logic [AddrW-1:0] rd_a;
  logic        rd_en;

  bstate_t st_r, st_nxt;
  job_t    j_r;
  logic [23:0] tl_r, tr_r, bl_r;
  logic signed [FracBits+11:0] i1_r [3], i2_r [3];
  logic        ov_r;
  out_item_t   ov_d_r;
  logic        stage_busy;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_a];
  end

  // reads: tl, tr, bl, br, then nearest; one per cycle
  always_comb begin
    rd_en = 1'b1;
    unique case (st_r)
      S_IDLE: rd_a = job.a_tl;
      S_RD0:  rd_a = j_r.a_tr;
      S_RD1:  rd_a = j_r.a_bl;
      S_RD2:  rd_a = j_r.a_br;
      S_RD3:  rd_a = j_r.a_u;
      default: rd_a = j_r.a_u;
    endcase
  end

  logic can_take;
  assign can_take = !ov_r || res_ready;

  always_comb begin
    st_nxt  = st_r;
    job_pop = 1'b0;
    unique case (st_r)
      S_IDLE: if (job_avail) begin st_nxt = S_RD0; job_pop = 1'b1; end
      S_RD0:  st_nxt = S_RD1;
      S_RD1:  st_nxt = S_RD2;
      S_RD2:  st_nxt = S_RD3;
      S_RD3:  st_nxt = S_MUL;
      S_MUL:  if (can_take) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  function automatic logic signed [FracBits+11:0] rowb(
      input logic signed [FracBits+2:0] a, input logic signed [FracBits+2:0] b,
      input logic [7:0] p, input logic [7:0] q);
    rowb = (FracBits+12)'(a) * (FracBits+12)'($signed({1'b0, p}))
         + (FracBits+12)'(b) * (FracBits+12)'($signed({1'b0, q}));
  endfunction

  // row blends, product of weight and row, truncation
  // the nearest pixel stays on rd_q for the whole of S_MUL
  logic signed [2*FracBits+15:0] f;
  logic signed [2*FracBits+15:0] fm;
  logic [7:0] ch [3];
  logic signed [FracBits+11:0] r1, r2;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      r1 = j_r.top ? i1_r[c] : $signed({4'b0, rd_q[23-8*c -: 8], {FracBits{1'b0}}});
      r2 = j_r.bot ? i2_r[c] : $signed({4'b0, rd_q[23-8*c -: 8], {FracBits{1'b0}}});
      f  = (2*FracBits+16)'(j_r.d3) * (2*FracBits+16)'(r1)
         + (2*FracBits+16)'(j_r.d4) * (2*FracBits+16)'(r2);
      fm = -f;
      ch[c] = f[2*FracBits+15] ? 8'(-(fm >>> (2*FracBits)))
                               : 8'(f >>> (2*FracBits));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_MUL && can_take) ov_r <= 1'b1;
      else if (res_ready) ov_r <= 1'b0;
    end
    if (job_pop) j_r <= job;
    unique case (st_r)
      S_RD0: tl_r <= rd_q;
      S_RD1: tr_r <= rd_q;
      S_RD2: bl_r <= rd_q;
      default: ;
    endcase
    if (st_r == S_RD3) begin
      for (int c = 0; c < 3; c++) begin
        i1_r[c] <= rowb(j_r.d1, j_r.d2, tl_r[23-8*c -: 8], tr_r[23-8*c -: 8]);
        i2_r[c] <= rowb(j_r.d1, j_r.d2, bl_r[23-8*c -: 8], rd_q[23-8*c -: 8]);
      end
    end
    if (st_r == S_MUL && can_take) begin
      ov_d_r.covered   <= j_r.covered;
      ov_d_r.out_red   <= j_r.covered ? ch[0] : 8'd0;
      ov_d_r.out_green <= j_r.covered ? ch[1] : 8'd0;
      ov_d_r.out_blue  <= j_r.covered ? ch[2] : 8'd0;
    end
  end

  assign stage_busy = (st_r != S_IDLE);
  assign busy       = stage_busy;
  assign res_valid  = ov_r;
  assign res        = ov_d_r;

endmodule
